[design/afb_pkg.sv]
package afb_pkg;

  localparam int MaxPayload = 240;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;
  localparam int StepW = 5;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgFrameKind = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameIdent = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDestAddr64 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgNetAddr16 = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTxOptions = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgCommandChars = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgPayloadLen = 3'd6;

  // frame kinds
  localparam logic KindTxReq = 1'b0;
  localparam logic KindCmd = 1'b1;

  localparam logic [7:0] StartDelim = 8'h7E;
  localparam logic [7:0] TypeTxReq = 8'h10;
  localparam logic [7:0] TypeCmd = 8'h08;
  localparam logic [7:0] RadiusByte = 8'h00;
  localparam logic [15:0] TxLenBase = 16'd14;
  localparam logic [15:0] CmdLenBase = 16'd4;
  localparam logic [StepW-1:0] TxHdrLen = 5'd17;
  localparam logic [StepW-1:0] CmdHdrLen = 5'd7;
  localparam logic [StepW-1:0] FirstSummed = 5'd3;

  localparam logic [15:0] NetAddrReset = 16'hFFFE;

  typedef struct packed {
    logic        frame_kind;
    logic [7:0]  frame_ident;
    logic [63:0] dest_addr64;
    logic [15:0] net_addr16;
    logic [7:0]  tx_options;
    logic [15:0] command_chars;
    logic [7:0]  payload_len;
  } cfg_t;

endpackage

[design/afb_cfg_regs.sv]
module afb_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [afb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [afb_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output afb_pkg::cfg_t                 cfg_o
);
  import afb_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_kind    <= KindTxReq;
      cfg_q.frame_ident   <= '0;
      cfg_q.dest_addr64   <= '0;
      cfg_q.net_addr16    <= NetAddrReset;
      cfg_q.tx_options    <= '0;
      cfg_q.command_chars <= '0;
      cfg_q.payload_len   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFrameKind:    cfg_q.frame_kind    <= cfg_wdata_i[0];
        CfgFrameIdent:   cfg_q.frame_ident   <= cfg_wdata_i[7:0];
        CfgDestAddr64:   cfg_q.dest_addr64   <= cfg_wdata_i[63:0];
        CfgNetAddr16:    cfg_q.net_addr16    <= cfg_wdata_i[15:0];
        CfgTxOptions:    cfg_q.tx_options    <= cfg_wdata_i[7:0];
        CfgCommandChars: cfg_q.command_chars <= cfg_wdata_i[15:0];
        CfgPayloadLen:   cfg_q.payload_len   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/afb_emitter.sv]
module afb_emitter #(
  parameter int MaxPayloadLen = afb_pkg::MaxPayload
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  afb_pkg::cfg_t  cfg_i,
  input  logic           item_valid_i,
  input  logic [7:0]     item_data_i,
  output logic           item_done_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           frame_end_o,
  output logic           run_last_o
);
  import afb_pkg::*;

  localparam logic [16:0] MaxPayloadW = 17'(MaxPayloadLen);

  logic [StepW-1:0] idx_q, idx_d;
  logic [7:0]       byte_pos_q, byte_pos_d;
  logic [7:0]       sum_q, sum_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q;
  logic             frame_end_q, run_last_q;

  logic [7:0]       eff_len;
  logic             len_zero, hdr, pay_done, has_ck, last, advance;
  logic [8:0]       pos_next;
  logic [15:0]      flen;
  logic [StepW-1:0] nh, nsteps;
  logic [7:0]       hdr_byte, cur_byte;
  logic             summed, is_ck;

  always_comb begin
    eff_len  = (17'(cfg_i.payload_len) > MaxPayloadW) ? MaxPayloadW[7:0] : cfg_i.payload_len;
    len_zero = (eff_len == 8'd0);
    hdr      = len_zero || (byte_pos_q == 8'd0);
    pos_next = {1'b0, byte_pos_q} + 9'd1;
    pay_done = (pos_next >= {1'b0, eff_len});
    has_ck   = len_zero || pay_done;
    nh       = hdr ? ((cfg_i.frame_kind == KindCmd) ? CmdHdrLen : TxHdrLen) : '0;
    nsteps   = nh + StepW'(!len_zero) + StepW'(has_ck);
    last     = (idx_q == nsteps - 5'd1);
    flen     = ((cfg_i.frame_kind == KindCmd) ? CmdLenBase : TxLenBase) + {8'd0, eff_len};
  end

  // header byte at the current step
  always_comb begin
    case (idx_q)
      5'd0:  hdr_byte = StartDelim;
      5'd1:  hdr_byte = flen[15:8];
      5'd2:  hdr_byte = flen[7:0];
      5'd3:  hdr_byte = (cfg_i.frame_kind == KindCmd) ? TypeCmd : TypeTxReq;
      5'd4:  hdr_byte = cfg_i.frame_ident;
      5'd5:  hdr_byte = (cfg_i.frame_kind == KindCmd) ? cfg_i.command_chars[15:8]
                                                      : cfg_i.dest_addr64[63:56];
      5'd6:  hdr_byte = (cfg_i.frame_kind == KindCmd) ? cfg_i.command_chars[7:0]
                                                      : cfg_i.dest_addr64[55:48];
      5'd7:  hdr_byte = cfg_i.dest_addr64[47:40];
      5'd8:  hdr_byte = cfg_i.dest_addr64[39:32];
      5'd9:  hdr_byte = cfg_i.dest_addr64[31:24];
      5'd10: hdr_byte = cfg_i.dest_addr64[23:16];
      5'd11: hdr_byte = cfg_i.dest_addr64[15:8];
      5'd12: hdr_byte = cfg_i.dest_addr64[7:0];
      5'd13: hdr_byte = cfg_i.net_addr16[15:8];
      5'd14: hdr_byte = cfg_i.net_addr16[7:0];
      5'd15: hdr_byte = RadiusByte;
      5'd16: hdr_byte = cfg_i.tx_options;
      default: hdr_byte = '0;
    endcase
  end

  always_comb begin
    if (idx_q < nh) begin
      cur_byte = hdr_byte;
      summed   = (idx_q >= FirstSummed);
      is_ck    = 1'b0;
    end else if (!len_zero && (idx_q == nh)) begin
      cur_byte = item_data_i;
      summed   = 1'b1;
      is_ck    = 1'b0;
    end else begin
      cur_byte = ~sum_q;  // 0xFF minus the sum
      summed   = 1'b0;
      is_ck    = 1'b1;
    end
  end

  assign advance     = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_done_o = advance && last;

  always_comb begin
    idx_d       = idx_q;
    byte_pos_d  = byte_pos_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
      idx_d       = last ? '0 : idx_q + 5'd1;
      if (hdr && (idx_q == 5'd0)) begin
        sum_d = '0;
      end else if (summed) begin
        sum_d = sum_q + cur_byte;
      end
      if (last) begin
        byte_pos_d = has_ck ? 8'd0 : pos_next[7:0];
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      byte_pos_q  <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      byte_pos_q  <= byte_pos_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q  <= cur_byte;
      frame_end_q <= is_ck;
      run_last_q  <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign frame_end_o = frame_end_q;
  assign run_last_o  = run_last_q;

endmodule

[design/api_frame_builder_with_checksum.sv]
// Wraps a stream of payload bytes into serial API frames (transmit request or command
// frame, chosen by frame_kind) with a trailing 8-bit checksum, emitting one frame byte
// per cycle while an input byte is held and the output is not stalled. A payload byte
// in the middle of a frame yields one frame byte; the first byte of a frame also sends
// the header first (17 bytes for a transmit request, 7 for a command frame), and the
// last byte sends the checksum byte after it. With payload_len zero every transaction
// produces a complete empty frame. The output is a single byte register; a held input
// byte is released as soon as its last frame byte is registered, so a new item is
// taken in the same cycle. Configuration must only be written while the block is idle.
module api_frame_builder_with_checksum #(
  parameter int MaxPayloadLen = afb_pkg::MaxPayload
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [afb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [afb_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic                          frame_end_o,
  output logic                          run_last_o
);
  import afb_pkg::*;

  cfg_t       cfg;
  logic       item_valid_q;
  logic [7:0] item_data_q;
  logic       item_done;

  afb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input holding register
  assign in_ready_o = !item_valid_q || item_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_data_q <= data_byte_i;
    end
  end

  afb_emitter #(
    .MaxPayloadLen (MaxPayloadLen)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid_q),
    .item_data_i  (item_data_q),
    .item_done_o  (item_done),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .frame_end_o  (frame_end_o),
    .run_last_o   (run_last_o)
  );

endmodule
